// ===== rtl/extended_8080_instruction_unit_core_defines.svh =====
// Assertion macros shared by the checker
`ifndef EXTENDED_8080_INSTRUCTION_UNIT_CORE_DEFINES_SVH
`define EXTENDED_8080_INSTRUCTION_UNIT_CORE_DEFINES_SVH

// same-cycle implication, checked out of reset
`define E8080IU_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("e8080iu assertion failed");

// next-cycle implication, checked out of reset
`define E8080IU_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("e8080iu assertion failed");

`endif

// ===== rtl/e8080iu_pkg.sv =====
package e8080iu_pkg;

  typedef enum logic [3:0] {
    ACT_PLAIN = 4'd0,
    ACT_DSUB  = 4'd1,
    ACT_DCMP  = 4'd2,
    ACT_DADC  = 4'd3,
    ACT_ANX   = 4'd4,
    ACT_ORX   = 4'd5,
    ACT_XRX   = 4'd6,
    ACT_LHLX  = 4'd7,
    ACT_SHLX  = 4'd8,
    ACT_JOF   = 4'd9,
    ACT_SMF0  = 4'd10,
    ACT_SMF1  = 4'd11,
    ACT_RS    = 4'd12,
    ACT_MB    = 4'd13
  } action_e;

  typedef enum logic [1:0] {
    PFX_IDLE   = 2'd0,
    PFX_ACTIVE = 2'd1,
    PFX_ARMED  = 2'd2
  } pfx_e;

  localparam int unsigned FlagCy = 0;
  localparam int unsigned FlagP  = 2;
  localparam int unsigned FlagOf = 5;
  localparam int unsigned FlagZ  = 6;
  localparam int unsigned FlagS  = 7;

  localparam logic [7:0] XchgOpcode = 8'hEB;

  localparam logic [3:0] TsOp    = 4'd10;
  localparam logic [3:0] TsPfx   = 4'd4;
  localparam logic [3:0] TsSmf0  = 4'd8;
  localparam logic [3:0] TsSmf1  = 4'd9;
  localparam logic [3:0] TsPlain = 4'd0;

  localparam int unsigned InDataW  = 128;
  localparam int unsigned InUserW  = 4;
  localparam int unsigned OutDataW = 80;

  typedef struct packed {
    logic [3:0]  action;
    logic [15:0] hl_in;
    logic [15:0] pair_value;
    logic [7:0]  acc;
    logic [7:0]  flags_in;
    logic [7:0]  mem_byte;
    logic [15:0] mem_word;
    logic [15:0] de_value;
    logic [7:0]  next_opcode;
    logic [15:0] jump_target;
    logic [15:0] pc_in;
  } in_item_t;

  typedef struct packed {
    logic [15:0] hl_out;
    logic [7:0]  flags_out;
    logic        write_enable;
    logic        write_is_word;
    logic [15:0] write_address;
    logic [15:0] write_data;
    logic [15:0] pc_out;
    logic        data_bank;
    logic        prefix_pending;
    logic [3:0]  t_states;
  } out_item_t;

  typedef struct packed {
    logic [15:0] alt_hl;
    logic        bank_flag;
    pfx_e        mb_state;
    pfx_e        rs_state;
  } unit_state_t;

endpackage

// ===== rtl/e8080iu_exec.sv =====
module e8080iu_exec import e8080iu_pkg::*; (
  input  in_item_t    item_i,
  input  unit_state_t state_i,
  output unit_state_t state_o,
  output out_item_t   result_o
);

  logic [16:0] diff;
  logic [16:0] sum;
  logic [7:0]  lres;
  logic        mb_active;
  logic        borrow;
  logic [15:0] hl;
  logic [15:0] alt;
  logic [7:0]  flags;
  logic        bank;
  pfx_e        rs_st;
  pfx_e        mb_st;
  out_item_t   res;

  always_comb begin
    mb_active = (state_i.mb_state != PFX_IDLE);
    borrow    = mb_active & item_i.flags_in[FlagCy];
    diff      = {1'b0, item_i.hl_in} - {1'b0, item_i.pair_value} - {16'd0, borrow};
    sum       = {1'b0, item_i.hl_in} + {1'b0, item_i.pair_value}
              + {16'd0, item_i.flags_in[FlagCy]};
    case (action_e'(item_i.action))
      ACT_ANX: lres = item_i.mem_byte & item_i.acc;
      ACT_ORX: lres = item_i.mem_byte | item_i.acc;
      default: lres = item_i.mem_byte ^ item_i.acc;
    endcase

    hl    = item_i.hl_in;
    alt   = state_i.alt_hl;
    flags = item_i.flags_in;
    bank  = state_i.bank_flag;
    rs_st = state_i.rs_state;
    mb_st = state_i.mb_state;
    res   = '0;
    res.pc_out = item_i.pc_in;
    res.t_states = TsPlain;

    case (action_e'(item_i.action))
      ACT_DSUB, ACT_DCMP: begin
        if (action_e'(item_i.action) == ACT_DSUB) begin
          hl = diff[15:0];
        end
        flags[FlagS]  = diff[15];
        flags[FlagZ]  = (diff[15:0] == 16'd0);
        flags[FlagCy] = diff[16];
        res.t_states  = TsOp;
      end
      ACT_DADC: begin
        hl            = sum[15:0];
        flags[FlagCy] = sum[16];
        res.t_states  = TsOp;
      end
      ACT_ANX, ACT_ORX, ACT_XRX: begin
        res.write_enable  = 1'b1;
        res.write_address = item_i.hl_in;
        res.write_data    = {8'd0, lres};
        flags[FlagS]  = lres[7];
        flags[FlagZ]  = (lres == 8'd0);
        flags[FlagP]  = ~^lres;
        flags[FlagCy] = 1'b0;
        res.t_states  = TsOp;
      end
      ACT_LHLX: begin
        hl           = item_i.mem_word;
        res.t_states = TsOp;
      end
      ACT_SHLX: begin
        res.write_enable  = 1'b1;
        res.write_is_word = 1'b1;
        res.write_address = item_i.de_value;
        res.write_data    = item_i.hl_in;
        res.t_states      = TsOp;
      end
      ACT_JOF: begin
        res.pc_out   = item_i.flags_in[FlagOf] ? item_i.jump_target : item_i.pc_in + 16'd2;
        res.t_states = TsOp;
      end
      ACT_SMF0, ACT_SMF1: begin
        bank         = (action_e'(item_i.action) == ACT_SMF1);
        res.pc_out   = item_i.pc_in + 16'd1;
        res.t_states = bank ? TsSmf1 : TsSmf0;
      end
      ACT_RS: begin
        if (item_i.next_opcode != XchgOpcode && state_i.rs_state == PFX_IDLE) begin
          hl    = state_i.alt_hl;
          alt   = item_i.hl_in;
          rs_st = PFX_ARMED;
        end
        res.t_states = TsPfx;
      end
      ACT_MB: begin
        mb_st        = PFX_ARMED;
        mb_active    = 1'b1;
        res.t_states = TsPfx;
      end
      default: ;
    endcase

    res.data_bank = bank ^ mb_active;

    // retire prefixes; an active RS swaps back here
    case (rs_st)
      PFX_ARMED:  rs_st = PFX_ACTIVE;
      PFX_ACTIVE: begin
        res.hl_out = alt;
        alt        = hl;
        rs_st      = PFX_IDLE;
      end
      default:    rs_st = PFX_IDLE;
    endcase
    if (state_i.rs_state != PFX_ACTIVE) begin
      res.hl_out = hl;
    end
    mb_st = (mb_st == PFX_ARMED) ? PFX_ACTIVE : PFX_IDLE;

    res.flags_out      = flags;
    res.prefix_pending = (rs_st != PFX_IDLE) || (mb_st != PFX_IDLE);

    state_o.alt_hl    = alt;
    state_o.bank_flag = bank;
    state_o.mb_state  = mb_st;
    state_o.rs_state  = rs_st;
    result_o          = res;
  end

endmodule

// ===== rtl/e8080iu_state.sv =====
module e8080iu_state import e8080iu_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  unit_state_t state_d_i,
  output unit_state_t state_q_o
);

  unit_state_t state_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '{alt_hl: 16'd0, bank_flag: 1'b0, mb_state: PFX_IDLE, rs_state: PFX_IDLE};
    end else if (en_i) begin
      state_q <= state_d_i;
    end
  end

  assign state_q_o = state_q;

endmodule

// ===== rtl/extended_8080_instruction_unit_core.sv =====
// channel  | valid / ready                   | payload
// ---------+---------------------------------+-------------------------------
// input    | s_axis_tvalid_i/s_axis_tready_o | s_axis_tdata_i, s_axis_tuser_i
// output   | m_axis_tvalid_o/m_axis_tready_i | m_axis_tdata_o
//
// One instruction per cycle sustained while m_axis_tready_i stays high; an instruction passes through
// the input register, then through the execute logic into the result register.
// The prefix/bank state updates when a word moves from input to result register.
// rst_ni clears valids and prefix state (alt HL and bank flag to zero).
// A stalled result holds while the input register can still take one more word if it is empty.
module extended_8080_instruction_unit_core import e8080iu_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  // hl_in, pair_value, acc, flags_in, mem_byte, mem_word, de_value,
  // next_opcode, jump_target, pc_in
  input  logic [InDataW-1:0]  s_axis_tdata_i,
  // action
  input  logic [InUserW-1:0]  s_axis_tuser_i,
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // hl_out, flags_out, write_enable, write_is_word, write_address,
  // write_data, pc_out, data_bank, prefix_pending, t_states
  output logic [OutDataW-1:0] m_axis_tdata_o
);

  in_item_t    in_q, in_d;
  logic        in_valid_q, in_valid_d;
  out_item_t   out_q, out_d;
  logic        out_valid_q, out_valid_d;
  logic        advance;
  logic        s_accept;
  unit_state_t state_q, state_d;

  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;
  assign s_accept        = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    in_d.action      = s_axis_tuser_i;
    in_d.hl_in       = s_axis_tdata_i[15:0];
    in_d.pair_value  = s_axis_tdata_i[31:16];
    in_d.acc         = s_axis_tdata_i[39:32];
    in_d.flags_in    = s_axis_tdata_i[47:40];
    in_d.mem_byte    = s_axis_tdata_i[55:48];
    in_d.mem_word    = s_axis_tdata_i[71:56];
    in_d.de_value    = s_axis_tdata_i[87:72];
    in_d.next_opcode = s_axis_tdata_i[95:88];
    in_d.jump_target = s_axis_tdata_i[111:96];
    in_d.pc_in       = s_axis_tdata_i[127:112];
    in_valid_d  = s_accept ? 1'b1 : (advance ? 1'b0 : in_valid_q);
    out_valid_d = advance ? 1'b1 : (m_axis_tready_i ? 1'b0 : out_valid_q);
  end

  e8080iu_exec u_exec (
    .item_i   (in_q),
    .state_i  (state_q),
    .state_o  (state_d),
    .result_o (out_d)
  );

  e8080iu_state u_state (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (advance),
    .state_d_i (state_d),
    .state_q_o (state_q)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      in_q <= in_d;
    end
    if (advance) begin
      out_q <= out_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {out_q.t_states, out_q.prefix_pending, out_q.data_bank,
                            out_q.pc_out, out_q.write_data, out_q.write_address,
                            out_q.write_is_word, out_q.write_enable,
                            out_q.flags_out, out_q.hl_out};

endmodule

// ===== rtl/e8080iu_checker.sv =====
`include "extended_8080_instruction_unit_core_defines.svh"

module e8080iu_checker import e8080iu_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                m_axis_tvalid_o,
  input logic                m_axis_tready_i,
  input logic [OutDataW-1:0] m_axis_tdata_o
);

  logic        out_stall;
  logic        out_we;
  logic        out_ww;
  logic [31:0] out_wr;
  logic [3:0]  out_ts;

  assign out_stall = m_axis_tvalid_o && !m_axis_tready_i;
  assign out_we    = m_axis_tdata_o[24];
  assign out_ww    = m_axis_tdata_o[25];
  assign out_wr    = m_axis_tdata_o[57:26];
  assign out_ts    = m_axis_tdata_o[79:76];

  `E8080IU_ASSERT_NEXT(a_out_hold, out_stall, m_axis_tvalid_o && $stable(m_axis_tdata_o))

  `E8080IU_ASSERT_IMPL(a_no_write_zero, m_axis_tvalid_o && !out_we, out_wr == 32'd0)

  `E8080IU_ASSERT_IMPL(a_word_write, m_axis_tvalid_o && out_ww, out_we && out_ts == TsOp)

  `E8080IU_ASSERT_IMPL(a_plain_quiet, m_axis_tvalid_o && out_ts == TsPlain, !out_we)

endmodule

bind extended_8080_instruction_unit_core e8080iu_checker u_e8080iu_checker (.*);
